### sv/pdist_pkg.sv
// shared widths and payload types for the point to plane distance core
`default_nettype none
package pdist_pkg;
    localparam int COORD_W = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] plane_a_x;
        logic signed [COORD_W-1:0] plane_a_y;
        logic signed [COORD_W-1:0] plane_a_z;
        logic signed [COORD_W-1:0] plane_b_x;
        logic signed [COORD_W-1:0] plane_b_y;
        logic signed [COORD_W-1:0] plane_b_z;
        logic signed [COORD_W-1:0] plane_c_x;
        logic signed [COORD_W-1:0] plane_c_y;
        logic signed [COORD_W-1:0] plane_c_z;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] query_z;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] signed_distance;
        logic                      degenerate;
    } out_t;
endpackage
`default_nettype wire

### sv/pdist_mul.sv
// three stage signed multiplier built from four half width partial products
`default_nettype none
module pdist_mul #(
    parameter int AW = 35,
    parameter int BW = 35
) (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic signed [AW-1:0]        a,
    input  wire logic signed [BW-1:0]        b,
    output logic signed [AW+BW-1:0]          prod
);
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AW-1:0]       am_reg;
    logic [BW-1:0]       bm_reg;
    logic                sg1_reg;
    logic [AL+BL-1:0]    pll_reg;
    logic [AL+BH-1:0]    plh_reg;
    logic [AH+BL-1:0]    phl_reg;
    logic [AH+BH-1:0]    phh_reg;
    logic                sg2_reg;
    logic [PW-1:0]       mag;
    logic signed [PW-1:0] prod_reg;

    always_comb begin
        mag = PW'(pll_reg) + (PW'(plh_reg) << BL) + (PW'(phl_reg) << AL)
            + (PW'(phh_reg) << (AL + BL));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            am_reg   <= a[AW-1] ? AW'(-a) : AW'(a);
            bm_reg   <= b[BW-1] ? BW'(-b) : BW'(b);
            sg1_reg  <= a[AW-1] ^ b[BW-1];
            pll_reg  <= (AL+BL)'(am_reg[AL-1:0]) * (AL+BL)'(bm_reg[BL-1:0]);
            plh_reg  <= (AL+BH)'(am_reg[AL-1:0]) * (AL+BH)'(bm_reg[BW-1:BL]);
            phl_reg  <= (AH+BL)'(am_reg[AW-1:AL]) * (AH+BL)'(bm_reg[BL-1:0]);
            phh_reg  <= (AH+BH)'(am_reg[AW-1:AL]) * (AH+BH)'(bm_reg[BW-1:BL]);
            sg2_reg  <= sg1_reg;
            prod_reg <= sg2_reg ? $signed(-mag) : $signed(mag);
        end
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

### sv/pdist_front.sv
// edge vectors, cross product terms and the plane normal
`default_nettype none
module pdist_front #(
    parameter int W = pdist_pkg::COORD_W
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [W-1:0]           pa [3],
    input  wire logic signed [W-1:0]           pb [3],
    input  wire logic signed [W-1:0]           pc [3],
    input  wire logic signed [W-1:0]           q  [3],
    output logic                               out_valid,
    output logic signed [W:0]                  dx [3],
    output logic signed [2*W+2:0]              n  [3]
);
    localparam int DW = W + 1;
    localparam int NW = 2 * DW + 1;

    logic signed [DW-1:0]   ab_reg [3];
    logic signed [DW-1:0]   ac_reg [3];
    logic signed [DW-1:0]   dx1_reg [3];
    logic signed [DW-1:0]   dx2_reg [3];
    logic signed [DW-1:0]   dx3_reg [3];
    logic signed [2*DW-1:0] m1_reg [3];
    logic signed [2*DW-1:0] m2_reg [3];
    logic signed [NW-1:0]   n_reg [3];
    logic [2:0]             v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ab_reg[i]  <= DW'(pb[i]) - DW'(pa[i]);
                ac_reg[i]  <= DW'(pc[i]) - DW'(pa[i]);
                dx1_reg[i] <= DW'(q[i]) - DW'(pa[i]);
                dx2_reg[i] <= dx1_reg[i];
                dx3_reg[i] <= dx2_reg[i];
                n_reg[i]   <= NW'(m1_reg[i]) - NW'(m2_reg[i]);
            end
            m1_reg[0] <= (2*DW)'(ab_reg[1]) * (2*DW)'(ac_reg[2]);
            m2_reg[0] <= (2*DW)'(ab_reg[2]) * (2*DW)'(ac_reg[1]);
            m1_reg[1] <= (2*DW)'(ab_reg[2]) * (2*DW)'(ac_reg[0]);
            m2_reg[1] <= (2*DW)'(ab_reg[0]) * (2*DW)'(ac_reg[2]);
            m1_reg[2] <= (2*DW)'(ab_reg[0]) * (2*DW)'(ac_reg[1]);
            m2_reg[2] <= (2*DW)'(ab_reg[1]) * (2*DW)'(ac_reg[0]);
        end
    end

    assign out_valid = v_reg[2];
    assign dx = dx3_reg;
    assign n  = n_reg;
endmodule
`default_nettype wire

### sv/pdist_dot.sv
// dot(x-a, n) and dot(n, n) on split multipliers and an adder stage
`default_nettype none
module pdist_dot #(
    parameter int W = pdist_pkg::COORD_W
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic signed [W:0]       dx [3],
    input  wire logic signed [2*W+2:0]   n  [3],
    output logic                         out_valid,
    output logic signed [3*W+5:0]        dot,
    output logic signed [4*W+7:0]        nn
);
    localparam int DW   = W + 1;
    localparam int NW   = 2 * DW + 1;
    localparam int DOTW = DW + NW + 2;
    localparam int NNW  = 2 * NW + 2;

    logic signed [DW+NW-1:0] pd [3];
    logic signed [2*NW-1:0]  pn [3];
    logic signed [DOTW-1:0]  dot_reg;
    logic signed [NNW-1:0]   nn_reg;
    logic [3:0]              v_reg;

    for (genvar i = 0; i < 3; i++) begin : g_mul
        pdist_mul #(.AW(DW), .BW(NW)) u_mul_d (
            .aclk (aclk), .en (en), .a (dx[i]), .b (n[i]), .prod (pd[i])
        );
        pdist_mul #(.AW(NW), .BW(NW)) u_mul_n (
            .aclk (aclk), .en (en), .a (n[i]), .b (n[i]), .prod (pn[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dot_reg <= DOTW'(pd[0]) + DOTW'(pd[1]) + DOTW'(pd[2]);
            nn_reg  <= NNW'(pn[0]) + NNW'(pn[1]) + NNW'(pn[2]);
        end
    end

    assign out_valid = v_reg[3];
    assign dot = dot_reg;
    assign nn  = nn_reg;
endmodule
`default_nettype wire

### sv/pdist_root.sv
// rounded |dot|/sqrt(nn) by one result bit per stage, then clamp and sign
`default_nettype none
module pdist_root #(
    parameter int W = pdist_pkg::COORD_W
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic signed [3*W+5:0]   dot,
    input  wire logic signed [4*W+7:0]   nn,
    output logic                         out_valid,
    output logic signed [W-1:0]          dist_out,
    output logic                         degen
);
    localparam int DW   = W + 1;
    localparam int NW   = 2 * DW + 1;
    localparam int DOTW = DW + NW + 2;
    localparam int NNW  = 2 * NW + 2;
    localparam int SQW  = 2 * DOTW + 2;
    localparam int RW   = 2 * DOTW + 4;

    logic [DOTW-1:0]        dabs_reg;
    logic [3:0]             va_reg;
    logic                   nega_reg [4];
    logic                   dga_reg  [4];
    logic [NNW-1:0]         nna_reg  [4];
    logic signed [SQW-1:0]  sq;

    logic [RW-1:0]          rem_reg [W+1];
    logic [RW-1:0]          p_reg   [W+1];
    logic [W-1:0]           r_reg   [W+1];
    logic [NNW-1:0]         nns_reg [W+1];
    logic                   negs_reg [W+1];
    logic                   dgs_reg [W+1];
    logic                   vs_reg  [W+1];

    logic [W-1:0]           cap;
    logic [W-1:0]           rc;
    logic                   ov_reg;
    logic signed [W-1:0]    dist_reg;
    logic                   degen_reg;

    pdist_mul #(.AW(DOTW+1), .BW(DOTW+1)) u_mul_sq (
        .aclk (aclk),
        .en   (en),
        .a    ($signed({1'b0, dabs_reg})),
        .b    ($signed({1'b0, dabs_reg})),
        .prod (sq)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= '0;
        end else if (en) begin
            va_reg <= {va_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dabs_reg    <= dot[DOTW-1] ? DOTW'(-dot) : DOTW'(dot);
            nega_reg[0] <= dot[DOTW-1];
            dga_reg[0]  <= (nn == '0);
            nna_reg[0]  <= NNW'(nn);
            for (int i = 1; i < 4; i++) begin
                nega_reg[i] <= nega_reg[i-1];
                dga_reg[i]  <= dga_reg[i-1];
                nna_reg[i]  <= nna_reg[i-1];
            end
        end
    end

    // remainder 4*d^2 - (2r-1)^2*nn and running (2r-1)*nn, starting at r = 0
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg[0] <= 1'b0;
        end else if (en) begin
            vs_reg[0] <= va_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= (RW'($unsigned(sq)) << 2) - RW'(nna_reg[3]);
            p_reg[0]    <= RW'(0) - RW'(nna_reg[3]);
            r_reg[0]    <= '0;
            nns_reg[0]  <= nna_reg[3];
            negs_reg[0] <= nega_reg[3];
            dgs_reg[0]  <= dga_reg[3];
        end
    end

    for (genvar j = 0; j < W; j++) begin : g_bit
        localparam int K = W - 1 - j;
        logic [RW-1:0] trial;
        logic [RW-1:0] diff;
        logic          take;

        always_comb begin
            trial = (p_reg[j] << (K + 2)) + (RW'(nns_reg[j]) << (2 * K + 2));
            diff  = rem_reg[j] - trial;
            take  = !diff[RW-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vs_reg[j+1] <= 1'b0;
            end else if (en) begin
                vs_reg[j+1] <= vs_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1]  <= take ? diff : rem_reg[j];
                p_reg[j+1]    <= take ? p_reg[j] + (RW'(nns_reg[j]) << (K + 1)) : p_reg[j];
                r_reg[j+1]    <= take ? (r_reg[j] | (W'(1) << K)) : r_reg[j];
                nns_reg[j+1]  <= nns_reg[j];
                negs_reg[j+1] <= negs_reg[j];
                dgs_reg[j+1]  <= dgs_reg[j];
            end
        end
    end

    always_comb begin
        cap = negs_reg[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
        rc  = (r_reg[W] > cap) ? cap : r_reg[W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en) begin
            ov_reg <= vs_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            degen_reg <= dgs_reg[W];
            if (dgs_reg[W]) begin
                dist_reg <= '0;
            end else begin
                dist_reg <= negs_reg[W] ? $signed(W'(0) - rc) : $signed(rc);
            end
        end
    end

    assign out_valid = ov_reg;
    assign dist_out  = dist_reg;
    assign degen     = degen_reg;
endmodule
`default_nettype wire

### sv/signed_point_plane_distance_core.sv
// top level of the pipelined signed point to plane distance core
//
//  port group     dir  contents
//  s_valid/ready  in   in_t: three plane points and a query point, Q11.4
//  m_valid/ready  out  out_t: signed distance Q11.4 saturated, degenerate flag
//
//  one transaction per cycle while the output is not held
//  most of the pipeline depth is the bit-per-stage rounding root after the product stages
//  reset clears all valid bits; payload registers are not reset
//  when the output is held, the whole pipeline holds and s_ready drops
`default_nettype none
module signed_point_plane_distance_core #(
    parameter int COORD_WIDTH = pdist_pkg::COORD_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire pdist_pkg::in_t   s_payload,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pdist_pkg::out_t       m_payload
);
    localparam int W = COORD_WIDTH;

    logic                       en;
    logic signed [W-1:0]        pa [3];
    logic signed [W-1:0]        pb [3];
    logic signed [W-1:0]        pc [3];
    logic signed [W-1:0]        q  [3];
    logic                       f_valid;
    logic signed [W:0]          dx [3];
    logic signed [2*W+2:0]      n  [3];
    logic                       d_valid;
    logic signed [3*W+5:0]      dot;
    logic signed [4*W+7:0]      nn;
    logic                       r_valid;
    logic signed [W-1:0]        dist_val;
    logic                       degen;

    assign en      = !r_valid || m_ready;
    assign s_ready = en;

    assign pa[0] = W'(s_payload.plane_a_x);
    assign pa[1] = W'(s_payload.plane_a_y);
    assign pa[2] = W'(s_payload.plane_a_z);
    assign pb[0] = W'(s_payload.plane_b_x);
    assign pb[1] = W'(s_payload.plane_b_y);
    assign pb[2] = W'(s_payload.plane_b_z);
    assign pc[0] = W'(s_payload.plane_c_x);
    assign pc[1] = W'(s_payload.plane_c_y);
    assign pc[2] = W'(s_payload.plane_c_z);
    assign q[0]  = W'(s_payload.query_x);
    assign q[1]  = W'(s_payload.query_y);
    assign q[2]  = W'(s_payload.query_z);

    pdist_front #(.W(W)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .pa        (pa),
        .pb        (pb),
        .pc        (pc),
        .q         (q),
        .out_valid (f_valid),
        .dx        (dx),
        .n         (n)
    );

    pdist_dot #(.W(W)) u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .dx        (dx),
        .n         (n),
        .out_valid (d_valid),
        .dot       (dot),
        .nn        (nn)
    );

    pdist_root #(.W(W)) u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .dot       (dot),
        .nn        (nn),
        .out_valid (r_valid),
        .dist_out  (dist_val),
        .degen     (degen)
    );

    assign m_valid                   = r_valid;
    assign m_payload.signed_distance = pdist_pkg::COORD_W'(dist_val);
    assign m_payload.degenerate      = degen;
endmodule
`default_nettype wire

### sv/pdist_checker.sv
// port level checks for the distance core and their bind
`default_nettype none
module pdist_checker (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_valid,
    input wire logic            s_ready,
    input wire pdist_pkg::in_t  s_payload,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire pdist_pkg::out_t m_payload
);
    // an empty output side never blocks a transaction
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no pending result");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.degenerate) |-> (m_payload.signed_distance == '0))
        else $error("degenerate result with nonzero distance");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=> (s_valid && $stable(s_payload)))
        else $error("waiting input transaction changed");
endmodule

bind signed_point_plane_distance_core pdist_checker u_pdist_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
`default_nettype wire
